// ===== src/pim_pkg.sv =====
// shared types and constants for the priority inheritance mutex unit
// no dependencies; compiled first

package pim_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int TASK_ID_BITS  = 4;
    localparam int PRIORITY_BITS = 5;
    localparam int COUNT_BITS    = 8;
    localparam int WCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_LOCK   = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_CANCEL = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_ACQUIRED  = 4'd0,
        ST_RECURSIVE = 4'd1,
        ST_BUSY      = 4'd2,
        ST_QUEUED    = 4'd3,
        ST_QFULL     = 4'd4,
        ST_COUNTDEC  = 4'd5,
        ST_FREED     = 4'd6,
        ST_HANDED    = 4'd7,
        ST_NOTOWNER  = 4'd8,
        ST_CANCELLED = 4'd9,
        ST_NOTFOUND  = 4'd10,
        ST_COUNTFULL = 4'd11
    } status_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [TASK_ID_BITS-1:0]  requester_id;
        logic [PRIORITY_BITS-1:0] requester_priority;
        logic                     no_wait;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic                     owner_valid;
        logic [TASK_ID_BITS-1:0]  owner_id;
        logic                     boost_valid;
        logic [PRIORITY_BITS-1:0] boost_priority;
        logic                     restore_base;
        logic [TASK_ID_BITS-1:0]  handoff_id;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
    } cmd_t;

endpackage

// ===== src/pim_if.sv =====
// request and response channel interfaces for the mutex unit
// depends on pim_pkg

interface pim_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic [pim_pkg::TASK_ID_BITS-1:0]  requester_id;
    logic [pim_pkg::PRIORITY_BITS-1:0] requester_priority;
    logic                              no_wait;

    modport source (
        output valid, op, requester_id, requester_priority, no_wait,
        input  ready
    );
    modport sink (
        input  valid, op, requester_id, requester_priority, no_wait,
        output ready
    );
endinterface

interface pim_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [3:0]                        status;
    logic                              owner_valid;
    logic [pim_pkg::TASK_ID_BITS-1:0]  owner_id;
    logic                              boost_valid;
    logic [pim_pkg::PRIORITY_BITS-1:0] boost_priority;
    logic                              restore_base;
    logic [pim_pkg::TASK_ID_BITS-1:0]  handoff_id;

    modport source (
        output valid, status, owner_valid, owner_id, boost_valid, boost_priority,
               restore_base, handoff_id,
        input  ready
    );
    modport sink (
        input  valid, status, owner_valid, owner_id, boost_valid, boost_priority,
               restore_base, handoff_id,
        output ready
    );
endinterface

// ===== src/pim_ctrl.sv =====
// handshake controller: tracks the output register and issues execute commands
// depends on pim_pkg

module pim_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output pim_pkg::cmd_t cmd
);
    import pim_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // a new transaction may enter while the held result leaves
    assign in_ready = (state_reg == S_EMPTY) || out_ready;
    assign accept   = in_valid && in_ready;
    assign cmd.exec = accept;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_EMPTY:
            begin
                if (accept)
                    state_next = S_FULL;
            end
            S_FULL:
            begin
                if (out_ready && !accept)
                    state_next = S_EMPTY;
            end
            default:
            begin
                state_next = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_EMPTY;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_next == S_FULL);
        end
    end

endmodule

// ===== src/pim_datapath.sv =====
// mutex state, sorted wait queue and result register
// depends on pim_pkg

module pim_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  pim_pkg::cmd_t cmd,
    input  pim_pkg::req_t req,
    output pim_pkg::rsp_t rsp
);
    import pim_pkg::*;

    typedef enum logic [1:0] {
        Q_HOLD,
        Q_INSERT,
        Q_DROP
    } qact_t;

    logic                     held_reg, held_next;
    logic [TASK_ID_BITS-1:0]  holder_reg, holder_next;
    logic [COUNT_BITS-1:0]    rcount_reg, rcount_next;
    logic [PRIORITY_BITS-1:0] hpri_reg, hpri_next;
    logic [WCOUNT_BITS-1:0]   wcount_reg, wcount_next;

    logic [TASK_ID_BITS-1:0]  wid_reg   [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0]  wid_next  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] wpri_reg  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] wpri_next [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] slot_valid;
    logic [QUEUE_DEPTH-1:0] ge;
    logic [QUEUE_DEPTH-1:0] at_pos;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] after;

    qact_t q_act;
    logic  drop_all;
    rsp_t  rsp_next;
    rsp_t  rsp_reg;

    // per-slot compares and shift muxes
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_slot
        logic [TASK_ID_BITS-1:0]  id_up, id_dn;
        logic [PRIORITY_BITS-1:0] pri_up, pri_dn;

        assign slot_valid[k] = WCOUNT_BITS'(k) < wcount_reg;
        assign ge[k]         = slot_valid[k] && (wpri_reg[k] >= req.requester_priority);
        assign match[k]      = slot_valid[k] && (wid_reg[k] == req.requester_id);

        if (k == 0)
        begin : g_first
            assign at_pos[k] = !ge[k];
            assign after[k]  = match[k];
            assign id_dn     = wid_reg[k];
            assign pri_dn    = wpri_reg[k];
        end
        else
        begin : g_rest
            assign at_pos[k] = !ge[k] && ge[k-1];
            assign after[k]  = after[k-1] | match[k];
            assign id_dn     = wid_reg[k-1];
            assign pri_dn    = wpri_reg[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign id_up  = wid_reg[k];
            assign pri_up = wpri_reg[k];
        end
        else
        begin : g_inner
            assign id_up  = wid_reg[k+1];
            assign pri_up = wpri_reg[k+1];
        end

        always_comb
        begin
            wid_next[k]  = wid_reg[k];
            wpri_next[k] = wpri_reg[k];
            unique case (q_act)
                Q_INSERT:
                begin
                    if (at_pos[k])
                    begin
                        wid_next[k]  = req.requester_id;
                        wpri_next[k] = req.requester_priority;
                    end
                    else if (!ge[k])
                    begin
                        wid_next[k]  = id_dn;
                        wpri_next[k] = pri_dn;
                    end
                end
                Q_DROP:
                begin
                    if (drop_all || after[k])
                    begin
                        wid_next[k]  = id_up;
                        wpri_next[k] = pri_up;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        held_next   = held_reg;
        holder_next = holder_reg;
        rcount_next = rcount_reg;
        hpri_next   = hpri_reg;
        wcount_next = wcount_reg;
        q_act       = Q_HOLD;
        drop_all    = 1'b0;

        rsp_next                = '0;
        rsp_next.status         = ST_ACQUIRED;

        unique case (op_t'(req.op))
            OP_LOCK:
            begin
                if (held_reg && (holder_reg == req.requester_id))
                begin
                    if (rcount_reg == COUNT_MAX)
                        rsp_next.status = ST_COUNTFULL;
                    else
                    begin
                        rcount_next     = rcount_reg + COUNT_BITS'(1);
                        rsp_next.status = ST_RECURSIVE;
                    end
                end
                else if (!held_reg)
                begin
                    held_next       = 1'b1;
                    holder_next     = req.requester_id;
                    rcount_next     = COUNT_BITS'(1);
                    hpri_next       = req.requester_priority;
                    rsp_next.status = ST_ACQUIRED;
                end
                else if (req.no_wait)
                    rsp_next.status = ST_BUSY;
                else if (wcount_reg == WCOUNT_BITS'(QUEUE_DEPTH))
                    rsp_next.status = ST_QFULL;
                else
                begin
                    if (hpri_reg < req.requester_priority)
                    begin
                        hpri_next               = req.requester_priority;
                        rsp_next.boost_valid    = 1'b1;
                        rsp_next.boost_priority = req.requester_priority;
                    end
                    q_act           = Q_INSERT;
                    wcount_next     = wcount_reg + WCOUNT_BITS'(1);
                    rsp_next.status = ST_QUEUED;
                end
            end
            OP_UNLOCK:
            begin
                if (!held_reg || (holder_reg != req.requester_id))
                    rsp_next.status = ST_NOTOWNER;
                else if (rcount_reg > COUNT_BITS'(1))
                begin
                    rcount_next     = rcount_reg - COUNT_BITS'(1);
                    rsp_next.status = ST_COUNTDEC;
                end
                else
                begin
                    rsp_next.restore_base = 1'b1;
                    if (wcount_reg != '0)
                    begin
                        holder_next         = wid_reg[0];
                        hpri_next           = wpri_reg[0];
                        rcount_next         = COUNT_BITS'(1);
                        rsp_next.handoff_id = wid_reg[0];
                        q_act               = Q_DROP;
                        drop_all            = 1'b1;
                        wcount_next         = wcount_reg - WCOUNT_BITS'(1);
                        rsp_next.status     = ST_HANDED;
                    end
                    else
                    begin
                        held_next       = 1'b0;
                        holder_next     = '0;
                        rcount_next     = '0;
                        hpri_next       = '0;
                        rsp_next.status = ST_FREED;
                    end
                end
            end
            OP_CANCEL:
            begin
                if (after[QUEUE_DEPTH-1])
                begin
                    q_act           = Q_DROP;
                    wcount_next     = wcount_reg - WCOUNT_BITS'(1);
                    rsp_next.status = ST_CANCELLED;
                end
                else
                    rsp_next.status = ST_NOTFOUND;
            end
            OP_QUERY:
            begin
                rsp_next.status = held_reg ? ST_BUSY : ST_FREED;
            end
            default:
            begin
                rsp_next.status = ST_NOTFOUND;
            end
        endcase

        rsp_next.owner_valid = held_next;
        rsp_next.owner_id    = held_next ? holder_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 1'b0;
            holder_reg <= '0;
            rcount_reg <= '0;
            hpri_reg   <= '0;
            wcount_reg <= '0;
        end
        else if (cmd.exec)
        begin
            held_reg   <= held_next;
            holder_reg <= holder_next;
            rcount_reg <= rcount_next;
            hpri_reg   <= hpri_next;
            wcount_reg <= wcount_next;
        end
    end

    // queue entries and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            wid_reg  <= wid_next;
            wpri_reg <= wpri_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== src/priority_inheritance_mutex_unit.sv =====
// top level of the priority inheritance mutex unit
// depends on pim_pkg, pim_if, pim_ctrl and pim_datapath

// Lock unit for one recursive mutex with priority inheritance. Each request
// transaction on req (lock, unlock, cancel, query) produces exactly one
// response transaction on rsp. The unit takes one request per clock while
// the sink does not stall: the whole request, including the sorted insert
// into the 8-entry wait queue and the removal of a cancelled or handed-off
// waiter, is resolved combinationally by parallel compares across all queue
// slots and a per-slot shift mux. The response appears in the cycle after
// the request is accepted and is held in an output register; a new request
// is accepted in the same cycle in which the held response is taken, so an
// always-ready sink sees a sustained rate of one transaction per cycle. The
// queue slots never written hold no defined value but are never reported.

module priority_inheritance_mutex_unit (
    input logic   clk,
    input logic   rst_n,
    pim_req_if.sink   req,
    pim_rsp_if.source rsp
);
    import pim_pkg::*;

    cmd_t cmd;
    req_t req_bus;
    rsp_t rsp_bus;

    // gather the request payload
    assign req_bus.op                 = req.op;
    assign req_bus.requester_id       = req.requester_id;
    assign req_bus.requester_priority = req.requester_priority;
    assign req_bus.no_wait            = req.no_wait;

    // handshake and output register occupancy
    pim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // mutex state, wait queue and result register
    pim_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // spread the response payload onto the channel
    assign rsp.status         = rsp_bus.status;
    assign rsp.owner_valid    = rsp_bus.owner_valid;
    assign rsp.owner_id       = rsp_bus.owner_id;
    assign rsp.boost_valid    = rsp_bus.boost_valid;
    assign rsp.boost_priority = rsp_bus.boost_priority;
    assign rsp.restore_base   = rsp_bus.restore_base;
    assign rsp.handoff_id     = rsp_bus.handoff_id;

    // every accepted request leaves a response behind
    a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> rsp.valid)
        else $error("accepted request produced no response");

    // a handoff names the new owner
    a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_HANDED) |->
            (rsp.owner_valid && rsp.owner_id == rsp.handoff_id))
        else $error("handoff does not match new owner");

    // boosts only come from a queued lock
    a_boost_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.boost_valid) |-> (rsp.status == ST_QUEUED))
        else $error("boost reported without queuing");

    // a free mutex reports owner zero
    a_free_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.owner_valid) |-> (rsp.owner_id == '0))
        else $error("free mutex reports an owner");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for priority_inheritance_mutex_unit
// depends on pim_pkg, pim_if and the unit's rtl; needs no files or arguments

module tb;
    import pim_pkg::*;

    localparam int ID_TOP         = (1 << TASK_ID_BITS) - 1;
    localparam int PRI_TOP        = (1 << PRIORITY_BITS) - 1;
    localparam int RANDOM_ITEMS   = 270;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    // one row of the directed stimulus; typed rows carry their own expected response
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pim_req_if req_ch ();
    pim_rsp_if rsp_ch ();

    priority_inheritance_mutex_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // responses still owed by the unit, oldest first
    rsp_t expected_rsp[$];
    dir_row_t dir_rows[$];
    int fail_count;
    int idle_cycles;
    int rsp_stall;
    // when set, neither side inserts idle cycles
    bit no_idle;

    // mirror of the lock state
    logic                     mtx_held;
    logic [TASK_ID_BITS-1:0]  mtx_owner;
    logic [COUNT_BITS-1:0]    mtx_depth;
    logic [PRIORITY_BITS-1:0] mtx_pri;
    logic [TASK_ID_BITS-1:0]  wait_id [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] wait_pri [QUEUE_DEPTH];
    int                       wait_len;

    // clock with period 10
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // lock state mirror
    // ---------------------------------------------------------------

    // remove one waiter and close the gap behind it
    function automatic void drop_waiter(input int pos);
        int k;
        for (k = pos; k + 1 < wait_len; k++) begin
            wait_id[k]  = wait_id[k + 1];
            wait_pri[k] = wait_pri[k + 1];
        end
        wait_len--;
    endfunction

    // apply one request to the mirror and return the response it must produce
    function automatic rsp_t mutex_predict(input req_t r);
        rsp_t o;
        int   pos;
        int   hit;
        int   k;
        o = '0;
        case (op_t'(r.op))
            OP_LOCK: begin
                if (mtx_held && mtx_owner == r.requester_id) begin
                    // recursive lock; saturates at the top of the counter
                    if (mtx_depth == COUNT_MAX) begin
                        o.status = ST_COUNTFULL;
                    end
                    else begin
                        mtx_depth++;
                        o.status = ST_RECURSIVE;
                    end
                end
                else if (!mtx_held) begin
                    mtx_held  = 1'b1;
                    mtx_owner = r.requester_id;
                    mtx_depth = COUNT_BITS'(1);
                    mtx_pri   = r.requester_priority;
                    o.status  = ST_ACQUIRED;
                end
                else if (r.no_wait) begin
                    o.status = ST_BUSY;
                end
                else if (wait_len >= QUEUE_DEPTH) begin
                    o.status = ST_QFULL;
                end
                else begin
                    // owner inherits a more urgent waiter's priority
                    if (mtx_pri < r.requester_priority) begin
                        mtx_pri          = r.requester_priority;
                        o.boost_valid    = 1'b1;
                        o.boost_priority = r.requester_priority;
                    end
                    // sorted insert behind all entries of equal or higher priority
                    pos = 0;
                    while (pos < wait_len && wait_pri[pos] >= r.requester_priority)
                        pos++;
                    for (k = wait_len; k > pos; k--) begin
                        wait_id[k]  = wait_id[k - 1];
                        wait_pri[k] = wait_pri[k - 1];
                    end
                    wait_id[pos]  = r.requester_id;
                    wait_pri[pos] = r.requester_priority;
                    wait_len++;
                    o.status = ST_QUEUED;
                end
            end
            OP_UNLOCK: begin
                if (!mtx_held || mtx_owner != r.requester_id) begin
                    o.status = ST_NOTOWNER;
                end
                else if (mtx_depth > 1) begin
                    mtx_depth--;
                    o.status = ST_COUNTDEC;
                end
                else begin
                    o.restore_base = 1'b1;
                    if (wait_len > 0) begin
                        // head waiter becomes the owner
                        mtx_owner    = wait_id[0];
                        mtx_pri      = wait_pri[0];
                        mtx_depth    = COUNT_BITS'(1);
                        o.handoff_id = wait_id[0];
                        drop_waiter(0);
                        o.status = ST_HANDED;
                    end
                    else begin
                        mtx_held  = 1'b0;
                        mtx_owner = '0;
                        mtx_depth = '0;
                        mtx_pri   = '0;
                        o.status  = ST_FREED;
                    end
                end
            end
            OP_CANCEL: begin
                // only the first matching entry goes; a boost stays in place
                hit = -1;
                for (k = 0; k < wait_len; k++)
                    if (hit < 0 && wait_id[k] == r.requester_id)
                        hit = k;
                if (hit >= 0) begin
                    drop_waiter(hit);
                    o.status = ST_CANCELLED;
                end
                else begin
                    o.status = ST_NOTFOUND;
                end
            end
            default: begin
                o.status = mtx_held ? ST_BUSY : ST_FREED;
            end
        endcase
        o.owner_valid = mtx_held;
        o.owner_id    = mtx_held ? mtx_owner : '0;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic void add_row(input op_t op, input int id, input int pri, input bit nw,
                                    input bit typed, input status_t st, input bit ov,
                                    input int oid, input bit bv, input int bp,
                                    input bit rb, input int hid);
        dir_row_t row;
        row.req.op                 = op;
        row.req.requester_id       = id[TASK_ID_BITS-1:0];
        row.req.requester_priority = pri[PRIORITY_BITS-1:0];
        row.req.no_wait            = nw;
        row.typed                  = typed;
        row.want.status            = st;
        row.want.owner_valid       = ov;
        row.want.owner_id          = oid[TASK_ID_BITS-1:0];
        row.want.boost_valid       = bv;
        row.want.boost_priority    = bp[PRIORITY_BITS-1:0];
        row.want.restore_base      = rb;
        row.want.handoff_id        = hid[TASK_ID_BITS-1:0];
        dir_rows.push_back(row);
    endfunction

    function automatic req_t make_req(input op_t op, input int id, input int pri, input bit nw);
        req_t r;
        r.op                 = op;
        r.requester_id       = id[TASK_ID_BITS-1:0];
        r.requester_priority = pri[PRIORITY_BITS-1:0];
        r.no_wait            = nw;
        return r;
    endfunction

    // random request steered toward the owner and the queued tasks so that
    // recursion, handoff and cancel hits happen often; a few are pure noise
    function automatic req_t random_request();
        req_t r;
        int   sel;
        int   pick;
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        r.no_wait = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 5))
            0:       r.requester_priority = '0;
            1:       r.requester_priority = PRI_TOP[PRIORITY_BITS-1:0];
            default: r.requester_priority = PRIORITY_BITS'($urandom_range(0, PRI_TOP));
        endcase
        r.requester_id = TASK_ID_BITS'((pick < 50) ? $urandom_range(0, 5)
                                                   : $urandom_range(0, ID_TOP));
        if (sel < 5) begin
            r.op = 2'($urandom_range(0, 3));
        end
        else if (sel < 50) begin
            r.op = OP_LOCK;
            if (mtx_held && pick < 25)
                r.requester_id = mtx_owner;
            else if (wait_len > 0 && pick < 40)
                r.requester_id = wait_id[$urandom_range(0, wait_len - 1)];
        end
        else if (sel < 78) begin
            r.op = OP_UNLOCK;
            if (mtx_held && pick < 75)
                r.requester_id = mtx_owner;
        end
        else if (sel < 90) begin
            r.op = OP_CANCEL;
            if (wait_len > 0 && pick < 65)
                r.requester_id = wait_id[$urandom_range(0, wait_len - 1)];
        end
        else begin
            r.op = OP_QUERY;
        end
        return r;
    endfunction

    // drive one request transaction and record its expected response on acceptance
    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid              <= 1'b1;
        req_ch.op                 <= r.op;
        req_ch.requester_id       <= r.requester_id;
        req_ch.requester_priority <= r.requester_priority;
        req_ch.no_wait            <= r.no_wait;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // the mirror follows every accepted request, typed rows included
        predicted = mutex_predict(r);
        expected_rsp.push_back(typed ? want : predicted);
    endtask

    // hold off the sender until every outstanding response has come back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp.size() != 0);
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // reset and request driver
    // ---------------------------------------------------------------

    initial begin : stimulus
        rsp_t  none;
        req_t  r;
        logic [TASK_ID_BITS-1:0] sat_id;
        int    n;

        // every input known from time zero
        rst_n                     = 1'b0;
        req_ch.valid              = 1'b0;
        req_ch.op                 = OP_QUERY;
        req_ch.requester_id       = '0;
        req_ch.requester_priority = '0;
        req_ch.no_wait            = 1'b0;
        no_idle                   = 1'b0;
        fail_count                = 0;
        none                      = '0;

        mtx_held  = 1'b0;
        mtx_owner = '0;
        mtx_depth = '0;
        mtx_pri   = '0;
        wait_len  = 0;

        // directed rows: op, id, pri, no_wait, typed, then the typed response
        // (status, owner_valid, owner_id, boost_valid, boost_pri, restore, handoff)
        add_row(OP_QUERY,  0,  0, 0, 1, ST_FREED,     0,  0, 0,  0, 0, 0);
        add_row(OP_UNLOCK, 3,  0, 0, 1, ST_NOTOWNER,  0,  0, 0,  0, 0, 0);
        add_row(OP_CANCEL, 5,  0, 0, 1, ST_NOTFOUND,  0,  0, 0,  0, 0, 0);
        // free mutex is taken even with no_wait set
        add_row(OP_LOCK,   15, 0, 1, 1, ST_ACQUIRED,  1, 15, 0,  0, 0, 0);
        add_row(OP_LOCK,   15, 31, 0, 1, ST_RECURSIVE, 1, 15, 0,  0, 0, 0);
        // busy with no_wait: refused, no boost
        add_row(OP_LOCK,   2,  0, 1, 1, ST_BUSY,      1, 15, 0,  0, 0, 0);
        // queued at top priority boosts the owner from zero
        add_row(OP_LOCK,   2, 31, 0, 1, ST_QUEUED,    1, 15, 1, 31, 0, 0);
        add_row(OP_LOCK,   4, 31, 0, 1, ST_QUEUED,    1, 15, 0,  0, 0, 0);
        // same task queued twice
        add_row(OP_LOCK,   2, 10, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   7, 31, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   8,  5, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   9, 20, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   10, 0, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   11, 1, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);
        // eighth waiter is in; the next one is refused
        add_row(OP_LOCK,   12, 31, 0, 1, ST_QFULL,    1, 15, 0,  0, 0, 0);
        add_row(OP_QUERY,  0,  0, 0, 1, ST_BUSY,      1, 15, 0,  0, 0, 0);
        // cancel removes only the first entry of the repeated waiter
        add_row(OP_CANCEL, 2,  0, 0, 0, ST_CANCELLED, 0,  0, 0,  0, 0, 0);
        add_row(OP_CANCEL, 13, 0, 0, 1, ST_NOTFOUND,  1, 15, 0,  0, 0, 0);
        add_row(OP_UNLOCK, 15, 0, 0, 1, ST_COUNTDEC,  1, 15, 0,  0, 0, 0);
        add_row(OP_UNLOCK, 3,  0, 0, 1, ST_NOTOWNER,  1, 15, 0,  0, 0, 0);
        // final unlock hands off to the head waiter
        add_row(OP_UNLOCK, 15, 0, 0, 0, ST_HANDED,    0,  0, 0,  0, 0, 0);
        add_row(OP_QUERY,  0,  0, 0, 0, ST_BUSY,      0,  0, 0,  0, 0, 0);
        add_row(OP_LOCK,   0,  0, 0, 0, ST_QUEUED,    0,  0, 0,  0, 0, 0);

        // single reset pulse
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // sender waits for a fully drained unit once
        drain_responses();

        // random traffic with back-to-back stretches and one more drain
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 60 && n < 110) || (n >= 200 && n < 230);
            if (n == 150)
                drain_responses();
            r = random_request();
            send_request(r, 1'b0, none);
        end
        no_idle = 1'b0;

        // recursion count saturation: climb to the top, overrun it, step down a little
        sat_id = mtx_held ? mtx_owner : '0;
        repeat ((1 << COUNT_BITS) + 1)
            send_request(make_req(OP_LOCK, sat_id, $urandom_range(0, PRI_TOP), 1'b0), 1'b0, none);
        repeat (3)
            send_request(make_req(OP_UNLOCK, sat_id, 0, 1'b0), 1'b0, none);

        // wait out every outstanding response, then a few quiet cycles
        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_rsp.size() != 0) begin
            $error("%0d responses never arrived", expected_rsp.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // response sink and checker
    // ---------------------------------------------------------------

    // every response transaction is checked against the oldest expectation;
    // after each one the sink may stall for a random number of cycles
    initial begin : response_sink
        rsp_t want;
        rsp_ch.ready = 1'b0;
        rsp_stall    = 0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (rsp_ch.valid && rsp_ch.ready) begin
                    if (expected_rsp.size() == 0) begin
                        $error("response transaction with none outstanding: status %0d",
                               rsp_ch.status);
                        fail_count++;
                    end
                    else begin
                        want = expected_rsp.pop_front();
                        compare_field("status", 8'(want.status), 8'(rsp_ch.status));
                        compare_field("owner_valid", 8'(want.owner_valid),
                                      8'(rsp_ch.owner_valid));
                        compare_field("owner_id", 8'(want.owner_id), 8'(rsp_ch.owner_id));
                        compare_field("boost_valid", 8'(want.boost_valid),
                                      8'(rsp_ch.boost_valid));
                        compare_field("boost_priority", 8'(want.boost_priority),
                                      8'(rsp_ch.boost_priority));
                        compare_field("restore_base", 8'(want.restore_base),
                                      8'(rsp_ch.restore_base));
                        compare_field("handoff_id", 8'(want.handoff_id),
                                      8'(rsp_ch.handoff_id));
                    end
                    rsp_stall = no_idle ? 0 : $urandom_range(0, 15);
                end
                if (rsp_stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    rsp_stall--;
                end
                else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ---------------------------------------------------------------

    initial idle_cycles = 0;

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
